@@ hw/rtl/bwr_pkg.sv @@
`default_nettype none

package bwr_pkg;

  // payload widths
  localparam int ACC_W = 32;   // Q16.16 accelerations
  localparam int ANG_W = 16;   // binary angle, half turn = 2^(ANG_W-1)
  localparam int MAG_W = 31;   // table entry, unsigned Q1.30 in [0, 2^30]
  localparam int TRG_W = 32;   // signed sine / cosine, Q2.30
  localparam int PRD_W = 64;   // full products and sums
  localparam int FRAC  = 30;   // fraction bits dropped when rounding

  localparam int SINE_DEPTH_DEF = 1024;

  localparam logic [63:0]        HALF_PI_Q31 = 64'd3373259426;
  localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
  localparam logic signed [63:0] ROUND_Q30   = 64'sd536870912;

  // term / ((2k)(2k+1)) for the k-th series step
  function automatic logic [63:0] series_div(input logic [63:0] t, input int k);
    logic [63:0] q;
    case (k)
      1:       q = t / 64'd6;
      2:       q = t / 64'd20;
      3:       q = t / 64'd42;
      4:       q = t / 64'd72;
      5:       q = t / 64'd110;
      6:       q = t / 64'd156;
      7:       q = t / 64'd210;
      default: q = t / 64'd272;
    endcase
    return q;
  endfunction

  // sin(x) for x in Q31 by truncated Taylor series, returned in Q30, clamped
  function automatic logic [MAG_W-1:0] sine_entry(input logic [63:0] x);
    logic [63:0]        term;
    logic signed [63:0] s;
    term = x;
    s    = signed'(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x) >> 31;
      term = series_div((term * x) >> 31, k);
      if ((k & 1) != 0) begin
        s = s - signed'(term);
      end else begin
        s = s + signed'(term);
      end
    end
    if (s < 0) begin
      s = 64'sd0;
    end
    s = (s + 64'sd1) >>> 1;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    return s[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bwr_sin_rom.sv @@
`default_nettype none

// Quarter-wave sine table, DEPTH+1 entries, registered read.
module bwr_sin_rom #(
  parameter int DEPTH = bwr_pkg::SINE_DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk,
  input  wire logic [IDX_W-1:0]          addr,
  output logic      [bwr_pkg::MAG_W-1:0] data_r
);
  import bwr_pkg::*;

  logic [MAG_W-1:0] rom_w [DEPTH+1];

  for (genvar i = 0; i <= DEPTH; i++) begin : g_entry
    localparam logic [63:0] X = (HALF_PI_Q31 * 64'(i) + 64'(DEPTH / 2)) / 64'(DEPTH);
    assign rom_w[i] = sine_entry(X);
  end

  always_ff @(posedge clk) begin
    data_r <= rom_w[addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/body_to_world_accel_rotation.sv @@
`default_nettype none

// Result: strobe out_valid rises once an item taken at an edge with start high and busy low
//   has passed the registers v1_r, v2_r, v3_r, v4_r, v5_r and out_valid_r in that order.
// Throughput: one item per cycle, set by the six-register pipeline with one table read
//   port per angle lane; busy is always low since the receiver cannot stall.
// Reset: synchronous active-low rst_n clears all valid bits; payload registers are not reset.
module body_to_world_accel_rotation #(
  parameter int SINE_TABLE_DEPTH = bwr_pkg::SINE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic signed [bwr_pkg::ACC_W-1:0] in_accel_x,
  input  wire logic signed [bwr_pkg::ACC_W-1:0] in_accel_y,
  input  wire logic signed [bwr_pkg::ACC_W-1:0] in_accel_z,
  input  wire logic signed [bwr_pkg::ANG_W-1:0] in_angle_a,
  input  wire logic signed [bwr_pkg::ANG_W-1:0] in_angle_b,
  output logic                                  out_valid,
  output logic signed [bwr_pkg::ACC_W-1:0]      out_world_x,
  output logic signed [bwr_pkg::ACC_W-1:0]      out_world_y,
  output logic signed [bwr_pkg::ACC_W-1:0]      out_world_z
);
  import bwr_pkg::*;

  // Angle geometry: quarter turn in angle units and half of one table step in scaled units.
  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int QTR_SH  = ANG_W - 2;              // log2 of a quarter turn
  localparam int R_W     = QTR_SH + 1;             // holds 0 .. quarter turn
  localparam int SCL_W   = R_W + IDX_W;            // r * DEPTH + half step
  localparam int LANES   = 4;                      // sin a, cos a, sin b, cos b
  localparam logic [ANG_W-1:0] QUARTER  = ANG_W'(1) << QTR_SH;
  localparam logic [R_W-1:0]   QTR_R    = R_W'(1) << QTR_SH;
  localparam logic [SCL_W-1:0] HALF_STP = SCL_W'(1) << (QTR_SH - 1);

  localparam int L_SA = 0;
  localparam int L_CA = 1;
  localparam int L_SB = 2;
  localparam int L_CB = 3;

  localparam logic signed [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Q30 x Q30 product rounded half up back to Q30.
  function automatic logic signed [TRG_W-1:0] mul_q30(input logic signed [TRG_W-1:0] a,
                                                      input logic signed [TRG_W-1:0] b);
    logic signed [PRD_W-1:0] p;
    p = PRD_W'(a) * PRD_W'(b) + ROUND_Q30;
    return signed'(p[FRAC +: TRG_W]);
  endfunction

  // Drop Q30 fraction of a pre-rounded sum and clamp to the Q16.16 range.
  function automatic logic signed [ACC_W-1:0] sat_out(input logic signed [PRD_W-1:0] acc);
    logic [PRD_W-FRAC-ACC_W:0] top;
    logic signed [ACC_W-1:0]   res;
    top = acc[PRD_W-1:FRAC+ACC_W-1];
    if (top == '0 || top == '1) begin
      res = signed'(acc[FRAC +: ACC_W]);
    end else if (acc[PRD_W-1]) begin
      res = SAT_MIN;
    end else begin
      res = SAT_MAX;
    end
    return res;
  endfunction

  // No back-pressure on the result side, so the pipeline never stalls.
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------------------
  // Stage 1: angle to table index and sign per lane. Cosine is sine shifted
  // by a quarter turn; odd quadrants mirror, the lower half-turn negates.
  // ---------------------------------------------------------------------------
  logic [ANG_W-1:0] ang_w [LANES];
  assign ang_w[L_SA] = in_angle_a;
  assign ang_w[L_CA] = in_angle_a + QUARTER;
  assign ang_w[L_SB] = in_angle_b;
  assign ang_w[L_CB] = in_angle_b + QUARTER;

  logic [IDX_W-1:0] idx_nxt [LANES];
  logic [LANES-1:0] neg_nxt;

  for (genvar l = 0; l < LANES; l++) begin : g_idx
    logic [R_W-1:0]   r_w;
    logic [R_W-1:0]   rr_w;
    logic [SCL_W-1:0] scl_w;
    assign r_w   = {1'b0, ang_w[l][QTR_SH-1:0]};
    assign rr_w  = ang_w[l][QTR_SH] ? (QTR_R - r_w) : r_w;
    assign scl_w = SCL_W'(rr_w) * SCL_W'(SINE_TABLE_DEPTH) + HALF_STP;
    // scl_w >> QTR_SH never exceeds the depth, so it lands on a table entry
    assign idx_nxt[l] = scl_w[QTR_SH +: IDX_W];
    assign neg_nxt[l] = ang_w[l][ANG_W-1];
  end

  logic                    v1_r;
  logic [IDX_W-1:0]        idx1_r [LANES];
  logic [LANES-1:0]        neg1_r;
  logic signed [ACC_W-1:0] ax1_r, ay1_r, az1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= idx_nxt;
    neg1_r <= neg_nxt;
    ax1_r  <= in_accel_x;
    ay1_r  <= in_accel_y;
    az1_r  <= in_accel_z;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: table read, one port per lane.
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0]        mag2_r [LANES];
  logic                    v2_r;
  logic [LANES-1:0]        neg2_r;
  logic signed [ACC_W-1:0] ax2_r, ay2_r, az2_r;

  for (genvar l = 0; l < LANES; l++) begin : g_rom
    bwr_sin_rom #(
      .DEPTH (SINE_TABLE_DEPTH),
      .IDX_W (IDX_W)
    ) u_rom (
      .clk    (clk),
      .addr   (idx1_r[l]),
      .data_r (mag2_r[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    neg2_r <= neg1_r;
    ax2_r  <= ax1_r;
    ay2_r  <= ay1_r;
    az2_r  <= az1_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: signed trig values and the four trig cross products.
  // ---------------------------------------------------------------------------
  logic signed [TRG_W-1:0] trg_w [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_sign
    logic signed [TRG_W-1:0] pos_w;
    assign pos_w    = signed'({1'b0, mag2_r[l]});
    assign trg_w[l] = neg2_r[l] ? -pos_w : pos_w;
  end

  logic                    v3_r;
  logic signed [TRG_W-1:0] sa3_r, ca3_r, sb3_r, cb3_r;
  logic signed [TRG_W-1:0] sasb3_r, sacb3_r, casb3_r, cbca3_r;
  logic signed [ACC_W-1:0] ax3_r, ay3_r, az3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    sa3_r   <= trg_w[L_SA];
    ca3_r   <= trg_w[L_CA];
    sb3_r   <= trg_w[L_SB];
    cb3_r   <= trg_w[L_CB];
    sasb3_r <= mul_q30(trg_w[L_SA], trg_w[L_SB]);
    sacb3_r <= mul_q30(trg_w[L_SA], trg_w[L_CB]);
    casb3_r <= mul_q30(trg_w[L_CA], trg_w[L_SB]);
    cbca3_r <= mul_q30(trg_w[L_CB], trg_w[L_CA]);
    ax3_r   <= ax2_r;
    ay3_r   <= ay2_r;
    az3_r   <= az2_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: acceleration x coefficient products, Q16.16 x Q2.30 = Q46.
  // ---------------------------------------------------------------------------
  logic                    v4_r;
  logic signed [PRD_W-1:0] p_aycb4_r, p_azsb4_r;
  logic signed [PRD_W-1:0] p_axca4_r, p_aysasb4_r, p_azsacb4_r;
  logic signed [PRD_W-1:0] p_axsa4_r, p_aycasb4_r, p_azcbca4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    p_aycb4_r   <= PRD_W'(ay3_r) * PRD_W'(cb3_r);
    p_azsb4_r   <= PRD_W'(az3_r) * PRD_W'(sb3_r);
    p_axca4_r   <= PRD_W'(ax3_r) * PRD_W'(ca3_r);
    p_aysasb4_r <= PRD_W'(ay3_r) * PRD_W'(sasb3_r);
    p_azsacb4_r <= PRD_W'(az3_r) * PRD_W'(sacb3_r);
    p_axsa4_r   <= PRD_W'(ax3_r) * PRD_W'(sa3_r);
    p_aycasb4_r <= PRD_W'(ay3_r) * PRD_W'(casb3_r);
    p_azcbca4_r <= PRD_W'(az3_r) * PRD_W'(cbca3_r);
  end

  // ---------------------------------------------------------------------------
  // Stage 5: row sums plus the half-LSB rounding constant. Each product is
  // at most 2^61 in magnitude, so three of them plus the constant fit 64 bits.
  // ---------------------------------------------------------------------------
  logic                    v5_r;
  logic signed [PRD_W-1:0] accx5_r, accy5_r, accz5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    accx5_r <= p_aycb4_r - p_azsb4_r + ROUND_Q30;
    accy5_r <= p_axca4_r + p_aysasb4_r + p_azsacb4_r + ROUND_Q30;
    accz5_r <= p_aycasb4_r + p_azcbca4_r - p_axsa4_r + ROUND_Q30;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: shift to Q16.16, saturate, output registers.
  // ---------------------------------------------------------------------------
  logic                    out_valid_r;
  logic signed [ACC_W-1:0] world_x_r, world_y_r, world_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    world_x_r <= sat_out(accx5_r);
    world_y_r <= sat_out(accy5_r);
    world_z_r <= sat_out(accz5_r);
  end

  assign out_valid   = out_valid_r;
  assign out_world_x = world_x_r;
  assign out_world_y = world_y_r;
  assign out_world_z = world_z_r;

endmodule

`default_nettype wire
